FILE: src/rgbh_pkg.sv
// shared constants, command codes and control types for the rgb histogram overlay
package rgbh_pkg;

  // default configuration
  localparam int BINS_DEF       = 256;
  localparam int COUNT_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 12;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int PEAK_OUT_W = 20;

  // item commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } rgbh_cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD,
    ST_QUERY
  } rgbh_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic busy;
    logic clearing;
    logic add_wb;
    logic query_out;
  } rgbh_ctl_t;

endpackage

FILE: src/rgbh_ram.sv
// single-port-write, registered-read memory holding one channel's bin counts
module rgbh_ram #(
  parameter int DEPTH = rgbh_pkg::BINS_DEF,
  parameter int WIDTH = rgbh_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rgbh_bin.sv
// maps a signed fixed-point value to a clamped bin index, floor(value * bins)
module rgbh_bin #(
  parameter int BINS      = rgbh_pkg::BINS_DEF,
  parameter int FRAC_BITS = rgbh_pkg::FRAC_BITS_DEF
) (
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] value,
  output logic        [$clog2(BINS)-1:0]       bin
);

  localparam int AW = $clog2(BINS);
  localparam int PW = rgbh_pkg::SAMPLE_W + $clog2(BINS) + 2;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] scaled;

  // exact product and floor toward minus infinity
  assign prod   = PW'(value) * PW'(BINS);
  assign scaled = prod >>> FRAC_BITS;

  // clamp to the bin range
  always_comb begin
    priority if (prod < 0) begin
      bin = '0;
    end else if (scaled > PW'(BINS - 1)) begin
      bin = AW'(BINS - 1);
    end else begin
      bin = scaled[AW-1:0];
    end
  end

endmodule

FILE: src/rgbh_ctrl.sv
// sequencer: clear sweep, add read-modify-write and query read timing
module rgbh_ctrl #(
  parameter int BINS = rgbh_pkg::BINS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [1:0]              command,
  output logic [$clog2(BINS)-1:0] clr_addr,
  output rgbh_pkg::rgbh_ctl_t     ctl
);

  localparam int AW = $clog2(BINS);

  rgbh_pkg::rgbh_state_t state, state_next;
  logic clr_last;

  assign clr_last = (clr_addr == AW'(BINS - 1));

  // state register, reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == rgbh_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end else begin
      clr_addr <= '0;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next    = state;
    ctl.busy      = 1'b1;
    ctl.clearing  = 1'b0;
    ctl.add_wb    = 1'b0;
    ctl.query_out = 1'b0;
    unique case (state)
      rgbh_pkg::ST_IDLE: begin
        ctl.busy = 1'b0;
        if (start) begin
          unique case (command)
            rgbh_pkg::CMD_CLEAR: state_next = rgbh_pkg::ST_CLEAR;
            rgbh_pkg::CMD_ADD:   state_next = rgbh_pkg::ST_ADD;
            rgbh_pkg::CMD_QUERY: state_next = rgbh_pkg::ST_QUERY;
            default:             state_next = rgbh_pkg::ST_IDLE;
          endcase
        end
      end
      rgbh_pkg::ST_CLEAR: begin
        ctl.clearing = 1'b1;
        if (clr_last) begin
          state_next = rgbh_pkg::ST_IDLE;
        end
      end
      rgbh_pkg::ST_ADD: begin
        ctl.add_wb = 1'b1;
        state_next = rgbh_pkg::ST_IDLE;
      end
      rgbh_pkg::ST_QUERY: begin
        ctl.query_out = 1'b1;
        state_next    = rgbh_pkg::ST_IDLE;
      end
      default: begin
        state_next = rgbh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rgb_histogram_overlay.sv
// top level: three bin memories, peak register, query compare and result register
//
// Items are taken with start while busy is low. Add and query items each keep the
// block busy after acceptance (the read latency of the bin memories ahead of the
// write-back or compare), so a new item is not taken until the last one is through.
// A query result shows on the result ports with result_valid high for one cycle,
// after the bin memory read register and the result register; the receiver must
// take it then. A clear item, and reset, walk every bin address writing zero,
// holding busy from acceptance or reset until the last address is written. The
// polarity register may be written at any time with cfg_write and cfg_data.
module rgb_histogram_overlay #(
  parameter int BINS       = rgbh_pkg::BINS_DEF,
  parameter int COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = rgbh_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [1:0]                           command,
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_red,
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_green,
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_blue,
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] query_x,
  input  logic signed [rgbh_pkg::SAMPLE_W-1:0] query_y,
  input  logic                                 cfg_write,
  input  logic                                 cfg_data,
  output logic                                 busy,
  output logic                                 result_valid,
  output logic                                 red_lit,
  output logic                                 green_lit,
  output logic                                 blue_lit,
  output logic [rgbh_pkg::PEAK_OUT_W-1:0]      peak_count
);

  localparam int AW = $clog2(BINS);
  localparam int PW = rgbh_pkg::SAMPLE_W + COUNT_BITS + 1;
  localparam int LW = PW - FRAC_BITS;

  rgbh_pkg::rgbh_ctl_t ctl;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] bin_r, bin_g, bin_b, bin_x;
  logic [AW-1:0] raddr_r, raddr_g, raddr_b;
  logic [AW-1:0] idx_r, idx_g, idx_b;
  logic [AW-1:0] waddr_r, waddr_g, waddr_b;
  logic [COUNT_BITS-1:0] cnt_r, cnt_g, cnt_b;
  logic [COUNT_BITS-1:0] inc_r, inc_g, inc_b;
  logic [COUNT_BITS-1:0] wdata_r, wdata_g, wdata_b;
  logic [COUNT_BITS-1:0] peak, peak_next, max_rg, max_b;
  logic [COUNT_BITS+rgbh_pkg::PEAK_OUT_W-1:0] peak_ext;
  logic signed [PW-1:0] y_ext, peak_s, level_prod;
  logic signed [LW-1:0] level, level_next;
  logic signed [LW-1:0] cmp_r, cmp_g, cmp_b;
  logic accept, is_query, is_clear, mem_we, polarity;

  assign busy     = ctl.busy;
  assign accept   = start && !busy;
  assign is_query = (command == rgbh_pkg::CMD_QUERY);
  assign is_clear = (command == rgbh_pkg::CMD_CLEAR);

  rgbh_ctrl #(.BINS(BINS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .command  (command),
    .clr_addr (clr_addr),
    .ctl      (ctl)
  );

  // bin indexes for the three samples and the query coordinate
  rgbh_bin #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_bin_r (.value(sample_red),   .bin(bin_r));
  rgbh_bin #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_bin_g (.value(sample_green), .bin(bin_g));
  rgbh_bin #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_bin_b (.value(sample_blue),  .bin(bin_b));
  rgbh_bin #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_bin_x (.value(query_x),      .bin(bin_x));

  // read addresses, issued in the accept cycle
  assign raddr_r = is_query ? bin_x : bin_r;
  assign raddr_g = is_query ? bin_x : bin_g;
  assign raddr_b = is_query ? bin_x : bin_b;

  // hold add indexes for the write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= bin_r;
      idx_g <= bin_g;
      idx_b <= bin_b;
    end
  end

  // saturating increments
  assign inc_r = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign inc_g = (&cnt_g) ? cnt_g : cnt_g + 1'b1;
  assign inc_b = (&cnt_b) ? cnt_b : cnt_b + 1'b1;

  // write port: zero sweep or add write-back
  assign mem_we  = ctl.clearing || ctl.add_wb;
  assign waddr_r = ctl.clearing ? clr_addr : idx_r;
  assign waddr_g = ctl.clearing ? clr_addr : idx_g;
  assign waddr_b = ctl.clearing ? clr_addr : idx_b;
  assign wdata_r = ctl.clearing ? '0 : inc_r;
  assign wdata_g = ctl.clearing ? '0 : inc_g;
  assign wdata_b = ctl.clearing ? '0 : inc_b;

  rgbh_ram #(.DEPTH(BINS), .WIDTH(COUNT_BITS)) u_ram_r (
    .clk(clk), .we(mem_we), .waddr(waddr_r), .wdata(wdata_r), .raddr(raddr_r), .rdata(cnt_r)
  );
  rgbh_ram #(.DEPTH(BINS), .WIDTH(COUNT_BITS)) u_ram_g (
    .clk(clk), .we(mem_we), .waddr(waddr_g), .wdata(wdata_g), .raddr(raddr_g), .rdata(cnt_g)
  );
  rgbh_ram #(.DEPTH(BINS), .WIDTH(COUNT_BITS)) u_ram_b (
    .clk(clk), .we(mem_we), .waddr(waddr_b), .wdata(wdata_b), .raddr(raddr_b), .rdata(cnt_b)
  );

  // peak over the new counts
  assign max_rg    = (inc_r > inc_g) ? inc_r : inc_g;
  assign max_b     = (inc_b > max_rg) ? inc_b : max_rg;
  assign peak_next = (max_b > peak) ? max_b : peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (accept && is_clear) begin
      peak <= '0;
    end else if (ctl.add_wb) begin
      peak <= peak_next;
    end
  end

  // query level, floor(y * peak), registered at accept
  assign y_ext      = PW'(query_y);
  assign peak_s     = PW'({1'b0, peak});
  assign level_prod = y_ext * peak_s;
  assign level_next = LW'(level_prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (accept) begin
      level <= level_next;
    end
  end

  // polarity register
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity <= 1'b0;
    end else if (cfg_write) begin
      polarity <= cfg_data;
    end
  end

  // counts widened for the signed compare
  assign cmp_r    = LW'(cnt_r);
  assign cmp_g    = LW'(cnt_g);
  assign cmp_b    = LW'(cnt_b);
  assign peak_ext = {{rgbh_pkg::PEAK_OUT_W{1'b0}}, peak};

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.query_out;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.query_out) begin
      red_lit    <= (level <= cmp_r) ^ polarity;
      green_lit  <= (level <= cmp_g) ^ polarity;
      blue_lit   <= (level <= cmp_b) ^ polarity;
      peak_count <= peak_ext[rgbh_pkg::PEAK_OUT_W-1:0];
    end
  end

  // a result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // every accepted query gives a result after the bin read and the result register
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_query) |=> ##1 result_valid)
    else $error("query item lost its result");

  // peak only falls through a clear
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(accept && is_clear)) |-> (peak >= $past(peak)))
    else $error("peak decreased without a clear");

  // no memory write-back while idle
  assert property (@(posedge clk) disable iff (rst) !busy |-> !mem_we)
    else $error("bin memory written while idle");

endmodule

FILE: tb/sv/rgb_histogram_overlay_tb.sv
// self-checking testbench for the rgb histogram overlay: directed rows, then random phases
`timescale 1ns / 100ps

module rgb_histogram_overlay_tb;

  localparam int BINS = rgbh_pkg::BINS_DEF;
  localparam int FRAC = rgbh_pkg::FRAC_BITS_DEF;
  // count width of the block under test
  localparam int COUNT_W = rgbh_pkg::COUNT_BITS_DEF;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = BINS + 8;

  // random phase flavors
  localparam int MODE_WIDE   = 0;
  localparam int MODE_NARROW = 1;
  localparam int MODE_FILL   = 2;
  localparam logic [15:0] FILL_BASE = 16'h0A00;

  localparam logic [15:0] CORNER_VALUES [8] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0FFF, 16'h1000, 16'h000F, 16'h0010
  };

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic [rgbh_pkg::PEAK_OUT_W-1:0] peak;
  } pixel_t;

  typedef struct {
    logic [1:0] cmd;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] qx;
    logic [15:0] qy;
    bit typed;
    pixel_t pixel;
  } stim_row_t;

  localparam pixel_t ALL_LIT_EMPTY = {3'b111, 20'd0};

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = rgbh_pkg::CMD_CLEAR;
  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_red = '0;
  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_green = '0;
  logic signed [rgbh_pkg::SAMPLE_W-1:0] sample_blue = '0;
  logic signed [rgbh_pkg::SAMPLE_W-1:0] query_x = '0;
  logic signed [rgbh_pkg::SAMPLE_W-1:0] query_y = '0;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic busy;
  logic result_valid;
  logic red_lit;
  logic green_lit;
  logic blue_lit;
  logic [rgbh_pkg::PEAK_OUT_W-1:0] peak_count;

  // shadow histogram state
  logic [COUNT_W-1:0] hist [3][BINS];
  logic [COUNT_W-1:0] hist_peak;
  logic polarity;

  pixel_t pending_pixels [$];
  stim_row_t directed_rows [$];
  int mismatches = 0;

  rgb_histogram_overlay #(
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .sample_red(sample_red),
    .sample_green(sample_green),
    .sample_blue(sample_blue),
    .query_x(query_x),
    .query_y(query_y),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .busy(busy),
    .result_valid(result_valid),
    .red_lit(red_lit),
    .green_lit(green_lit),
    .blue_lit(blue_lit),
    .peak_count(peak_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // floor(v * BINS) in Q4.12, clamped to the bin range
  function automatic int bin_of_coord(input logic signed [15:0] v);
    longint prod;
    prod = longint'(v) * BINS;
    if (prod < 0) return 0;
    prod = prod >>> FRAC;
    if (prod > BINS - 1) return BINS - 1;
    return int'(prod);
  endfunction

  function automatic logic channel_lit(input longint level, input logic [COUNT_W-1:0] count);
    logic in_bar;
    in_bar = level <= longint'(count);
    return in_bar ^ polarity;
  endfunction

  // advance the shadow histograms by one accepted item
  task automatic histogram_step(input logic [1:0] cmd, input logic [15:0] r, input logic [15:0] g,
                                input logic [15:0] b, input logic [15:0] x, input logic [15:0] y,
                                input bit typed, input pixel_t typed_px);
    logic [15:0] samples [3];
    longint level;
    int idx;
    pixel_t px;
    samples = '{r, g, b};
    unique case (cmd)
      rgbh_pkg::CMD_CLEAR: begin
        foreach (hist[c, i]) hist[c][i] = '0;
        hist_peak = '0;
      end
      rgbh_pkg::CMD_ADD: begin
        for (int c = 0; c < 3; c++) begin
          idx = bin_of_coord(samples[c]);
          if (hist[c][idx] != COUNT_TOP) hist[c][idx] = hist[c][idx] + 1'b1;
          if (hist[c][idx] > hist_peak) hist_peak = hist[c][idx];
        end
      end
      rgbh_pkg::CMD_QUERY: begin
        idx = bin_of_coord(x);
        level = (longint'($signed(y)) * longint'(hist_peak)) >>> FRAC;
        px.red = channel_lit(level, hist[0][idx]);
        px.green = channel_lit(level, hist[1][idx]);
        px.blue = channel_lit(level, hist[2][idx]);
        px.peak = rgbh_pkg::PEAK_OUT_W'(hist_peak);
        pending_pixels.push_back(typed ? typed_px : px);
      end
      default: ;
    endcase
  endtask

  // present one item, optionally after an idle burst, and wait for its acceptance
  task automatic drive_item(input logic [1:0] cmd, input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] x, input logic [15:0] y,
                            input bit gaps, input bit typed, input pixel_t typed_px);
    if (gaps && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    sample_red <= r;
    sample_green <= g;
    sample_blue <= b;
    query_x <= x;
    query_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    histogram_step(cmd, r, g, b, x, y, typed, typed_px);
  endtask

  // polarity changes only once the block has drained and any clear walk is over
  task automatic write_polarity(input logic value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    polarity = value;
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [15:0] r, input logic [15:0] g,
                         input logic [15:0] b, input logic [15:0] x, input logic [15:0] y,
                         input bit typed = 1'b0, input pixel_t px = '0);
    stim_row_t row;
    row.cmd = cmd;
    row.red = r;
    row.green = g;
    row.blue = b;
    row.qx = x;
    row.qy = y;
    row.typed = typed;
    row.pixel = px;
    directed_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick_coord(input int mode);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CORNER_VALUES[$urandom_range(0, 7)];
    if (sel == 1) return 16'($urandom);
    if (mode == MODE_WIDE) return 16'($urandom_range(0, 4095));
    return 16'($urandom_range(0, 127));
  endfunction

  // mostly levels spread over 0..peak and a little beyond
  function automatic logic [15:0] pick_level_y();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CORNER_VALUES[$urandom_range(0, 7)];
    if (sel == 1) return 16'($urandom);
    return 16'($urandom_range(0, 4300));
  endfunction

  task automatic run_random(input int n_items, input int mode, input bit gaps);
    int done;
    int pick;
    logic [1:0] cmd;
    logic [15:0] r, g, b, x, y;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (mode == MODE_FILL) cmd = (pick < 85) ? rgbh_pkg::CMD_ADD : rgbh_pkg::CMD_QUERY;
      else if (pick < 2) cmd = rgbh_pkg::CMD_CLEAR;
      else if (pick < 5) cmd = CMD_UNUSED;
      else if (pick < 60) cmd = rgbh_pkg::CMD_ADD;
      else cmd = rgbh_pkg::CMD_QUERY;
      r = pick_coord(mode);
      g = pick_coord(mode);
      b = pick_coord(mode);
      x = pick_coord(mode);
      y = pick_level_y();
      // fill mode piles red and green into one bin to build tall counts
      if (mode == MODE_FILL) begin
        r = FILL_BASE | 16'($urandom_range(0, 15));
        g = FILL_BASE | 16'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) x = FILL_BASE | 16'($urandom_range(0, 15));
      end
      drive_item(cmd, r, g, b, x, y, gaps, 1'b0, '0);
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && result_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with no query waiting");
      end else begin
        want = pending_pixels.pop_front();
        if (red_lit !== want.red)
          report_mismatch($sformatf("red_lit got %b expected %b", red_lit, want.red));
        if (green_lit !== want.green)
          report_mismatch($sformatf("green_lit got %b expected %b", green_lit, want.green));
        if (blue_lit !== want.blue)
          report_mismatch($sformatf("blue_lit got %b expected %b", blue_lit, want.blue));
        if (peak_count !== want.peak)
          report_mismatch($sformatf("peak_count got %0d expected %0d", peak_count, want.peak));
      end
    end
  end

  // watchdog on cycles with no item and no result moving
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_valid) stall = 0;
      else stall++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    foreach (hist[c, i]) hist[c][i] = '0;
    hist_peak = '0;
    polarity = 1'b0;

    // empty histograms, extremes, clamping, negative level, unused command
    add_row(rgbh_pkg::CMD_QUERY, 16'h1111, 16'h2222, 16'h3333, 16'h0000, 16'h0000, 1'b1,
            ALL_LIT_EMPTY);
    add_row(rgbh_pkg::CMD_QUERY, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1,
            ALL_LIT_EMPTY);
    add_row(rgbh_pkg::CMD_ADD, 16'h0000, 16'h0FFF, 16'h8000, 16'h5555, 16'hAAAA);
    add_row(rgbh_pkg::CMD_ADD, 16'h7FFF, 16'h0010, 16'h7FFF, 16'hAAAA, 16'h5555);
    add_row(CMD_UNUSED, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0FFF, 16'h1000);
    add_row(rgbh_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h1000, 1'b1,
            ALL_LIT_EMPTY);
    add_row(rgbh_pkg::CMD_ADD, 16'h0800, 16'h0800, 16'h0800, 16'h0000, 16'h0000);
    add_row(rgbh_pkg::CMD_ADD, 16'h0800, 16'h0800, 16'h0FF0, 16'h0000, 16'h0000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h1000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h1001);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h1800);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h07F0, 16'h0001);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h07F0, 16'hFFFF);
    add_row(rgbh_pkg::CMD_ADD, 16'h1000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
    add_row(rgbh_pkg::CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h1000);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_polarity(1'b0);

    foreach (directed_rows[i])
      drive_item(directed_rows[i].cmd, directed_rows[i].red, directed_rows[i].green,
                 directed_rows[i].blue, directed_rows[i].qx, directed_rows[i].qy, 1'b1,
                 directed_rows[i].typed, directed_rows[i].pixel);

    write_polarity(1'b1);
    run_random(300, MODE_NARROW, 1'b1);
    write_polarity(1'b0);
    run_random(250, MODE_WIDE, 1'b1);
    write_polarity(1'b1);
    run_random(320, MODE_FILL, 1'b1);
    write_polarity(1'b0);
    run_random(200, MODE_NARROW, 1'b0);

    // drain and let the block settle
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
